// ----- rtl/line_rasterizer_defines.svh -----
// ----------------------------------------------------------------------------
// line_rasterizer_defines
// Assertion macros shared by the line rasterizer modules. They expect i_clk
// and an active-low synchronous i_rst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define LR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lr_pkg.sv -----
// ----------------------------------------------------------------------------
// lr_pkg
// Widths, types and register indexes shared by the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_BITS = 10;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int CLIP_BITS  = 11;
    localparam int CMP_BITS   = (COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CLIP_BITS-1:0] CLIP_RESET = CLIP_BITS'(500);

    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef logic [COORD_BITS-1:0]       t_coord;
    typedef logic [DELTA_BITS-1:0]       t_delta;
    typedef logic signed [ERR_BITS-1:0]  t_err;
    typedef logic [CLIP_BITS-1:0]        t_clip;
    typedef logic [CMP_BITS-1:0]         t_cmp;

    // line setup handed from the setup logic to the walker
    typedef struct packed {
        t_coord major_pos;
        t_coord minor_pos;
        t_coord major_end;
        t_delta major_delta;
        t_delta minor_delta;
        t_err   error_term;
        logic   minor_neg;
        logic   steep;
    } t_line;

    typedef struct packed {
        logic load;
        logic step;
    } t_walk_ctl;

endpackage

// ----- rtl/lr_setup.sv -----
// ----------------------------------------------------------------------------
// lr_setup
// Octant setup for a new line: picks the major axis, orders the endpoints
// so the major axis runs upward and derives the deltas and error term.
// ----------------------------------------------------------------------------
module lr_setup (
    input  lr_pkg::t_coord i_x_start,
    input  lr_pkg::t_coord i_y_start,
    input  lr_pkg::t_coord i_x_end,
    input  lr_pkg::t_coord i_y_end,
    output lr_pkg::t_line  o_line
);

    lr_pkg::t_coord dx;
    lr_pkg::t_coord dy;
    lr_pkg::t_coord ma0;
    lr_pkg::t_coord mi0;
    lr_pkg::t_coord ma1;
    lr_pkg::t_coord mi1;
    lr_pkg::t_coord lo_major;
    lr_pkg::t_coord lo_minor;
    lr_pkg::t_coord hi_major;
    lr_pkg::t_coord hi_minor;
    lr_pkg::t_coord minor_abs;
    logic           steep;

    assign dx = (i_x_start > i_x_end) ? (i_x_start - i_x_end) : (i_x_end - i_x_start);
    assign dy = (i_y_start > i_y_end) ? (i_y_start - i_y_end) : (i_y_end - i_y_start);
    assign steep = dy > dx;

    always_comb begin
        if (steep) begin
            ma0 = i_y_start;
            mi0 = i_x_start;
            ma1 = i_y_end;
            mi1 = i_x_end;
        end else begin
            ma0 = i_x_start;
            mi0 = i_y_start;
            ma1 = i_x_end;
            mi1 = i_y_end;
        end
    end

    // walk the major axis upward
    always_comb begin
        if (ma0 > ma1) begin
            lo_major = ma1;
            lo_minor = mi1;
            hi_major = ma0;
            hi_minor = mi0;
        end else begin
            lo_major = ma0;
            lo_minor = mi0;
            hi_major = ma1;
            hi_minor = mi1;
        end
    end

    assign minor_abs = (lo_minor > hi_minor) ? (lo_minor - hi_minor)
                                             : (hi_minor - lo_minor);

    always_comb begin
        o_line.major_pos   = lo_major;
        o_line.minor_pos   = lo_minor;
        o_line.major_end   = hi_major;
        o_line.major_delta = lr_pkg::t_delta'(hi_major - lo_major);
        o_line.minor_delta = lr_pkg::t_delta'(minor_abs);
        o_line.error_term  = lr_pkg::t_err'(minor_abs) - lr_pkg::t_err'(hi_major - lo_major);
        o_line.minor_neg   = hi_minor < lo_minor;
        o_line.steep       = steep;
    end

endmodule

// ----- rtl/lr_walker.sv -----
// ----------------------------------------------------------------------------
// lr_walker
// Line state and pixel stepping. Holds the current Bresenham state and the
// result register; emits one pixel per step while a line is active and advances the line.
// ----------------------------------------------------------------------------
`include "line_rasterizer_defines.svh"

module lr_walker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lr_pkg::t_walk_ctl i_ctl,
    input  lr_pkg::t_line     i_line,
    input  lr_pkg::t_clip     i_clip_width,
    input  lr_pkg::t_clip     i_clip_height,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output lr_pkg::t_coord    o_pixel_x,
    output lr_pkg::t_coord    o_pixel_y,
    output logic              o_pixel_inside,
    output logic              o_last_pixel
);

    lr_pkg::t_coord r_major_pos;
    lr_pkg::t_coord r_minor_pos;
    lr_pkg::t_coord r_major_end;
    lr_pkg::t_delta r_major_delta;
    lr_pkg::t_delta r_minor_delta;
    lr_pkg::t_err   r_error_term;
    logic           r_minor_neg;
    logic           r_steep;
    logic           r_active;
    logic           r_out_valid;
    lr_pkg::t_coord r_pixel_x;
    lr_pkg::t_coord r_pixel_y;
    logic           r_pixel_inside;
    logic           r_last_pixel;

    lr_pkg::t_coord n_minor_pos;
    lr_pkg::t_err   n_error_term;
    lr_pkg::t_coord px;
    lr_pkg::t_coord py;
    logic           last;
    logic           step_fire;
    logic           err_ge;

    assign step_fire = i_ctl.step && r_active;
    assign last      = r_major_pos == r_major_end;
    assign err_ge    = !r_error_term[lr_pkg::ERR_BITS-1];

    assign px = r_steep ? r_minor_pos : r_major_pos;
    assign py = r_steep ? r_major_pos : r_minor_pos;

    always_comb begin
        n_minor_pos  = r_minor_pos;
        n_error_term = r_error_term + lr_pkg::t_err'(r_minor_delta);
        if (err_ge) begin
            n_minor_pos  = r_minor_neg ? (r_minor_pos - lr_pkg::t_coord'(1))
                                       : (r_minor_pos + lr_pkg::t_coord'(1));
            n_error_term = n_error_term - lr_pkg::t_err'(r_major_delta);
        end
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major_pos   <= '0;
            r_minor_pos   <= '0;
            r_major_end   <= '0;
            r_major_delta <= '0;
            r_minor_delta <= '0;
            r_error_term  <= '0;
            r_minor_neg   <= 1'b0;
            r_steep       <= 1'b0;
            r_active      <= 1'b0;
        end else if (i_ctl.load) begin
            r_major_pos   <= i_line.major_pos;
            r_minor_pos   <= i_line.minor_pos;
            r_major_end   <= i_line.major_end;
            r_major_delta <= i_line.major_delta;
            r_minor_delta <= i_line.minor_delta;
            r_error_term  <= i_line.error_term;
            r_minor_neg   <= i_line.minor_neg;
            r_steep       <= i_line.steep;
            r_active      <= 1'b1;
        end else if (step_fire) begin
            if (last) begin
                r_active <= 1'b0;
            end else begin
                r_major_pos  <= r_major_pos + lr_pkg::t_coord'(1);
                r_minor_pos  <= n_minor_pos;
                r_error_term <= n_error_term;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_pixel_x      <= px;
            r_pixel_y      <= py;
            r_pixel_inside <= (lr_pkg::t_cmp'(px) < lr_pkg::t_cmp'(i_clip_width)) &&
                              (lr_pkg::t_cmp'(py) < lr_pkg::t_cmp'(i_clip_height));
            r_last_pixel   <= last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_x      = r_pixel_x;
    assign o_pixel_y      = r_pixel_y;
    assign o_pixel_inside = r_pixel_inside;
    assign o_last_pixel   = r_last_pixel;

    `LR_ASSERT_SAME(a_step_room, i_ctl.step, !r_out_valid || !i_out_stall,
        "step issued while the result register is still held")
    `LR_ASSERT_SAME(a_load_step_excl, i_ctl.load, !i_ctl.step,
        "load and step issued together")
    `LR_ASSERT_NEXT(a_step_emits, step_fire, r_out_valid,
        "active step gave no result")
    `LR_ASSERT_NEXT(a_last_ends, step_fire && last, !r_active,
        "line still active after its last pixel")
    `LR_ASSERT_SAME(a_major_bound, r_active, r_major_pos <= r_major_end,
        "major position ran past the line end")

endmodule

// ----- rtl/line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line generator, one pixel per step transaction.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): a transaction with i_kind load
// sets up a new line from the two endpoints and gives no output; a
// transaction with i_kind step emits the next pixel of the active line, or
// nothing when no line is active. A load while a line is active replaces it.
// Output channel (o_out_valid / i_out_stall): one transaction per pixel with
// its coordinates, an inside-clip flag and a last-pixel flag.
// Throughput: one input transaction per cycle while o_in_stall is low; a line
// of n pixels takes one load and n step transactions. A step accepted goes
// into the input register; its pixel passes through the result register to
// the output. The setup and step logic both sit in a single stage between them.
// Clip registers are written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must write them only while the block is idle; the block does not enforce it.
// Reset: no line active, no output pending, clip width and height at 500.
// When the receiver stalls, the result holds and the input register fills;
// o_in_stall then rises until the result is taken.
// ----------------------------------------------------------------------------
module line_rasterizer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lr_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [lr_pkg::CLIP_BITS-1:0]     i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_kind,
    input  lr_pkg::t_coord                   i_x_start,
    input  lr_pkg::t_coord                   i_y_start,
    input  lr_pkg::t_coord                   i_x_end,
    input  lr_pkg::t_coord                   i_y_end,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output lr_pkg::t_coord                   o_pixel_x,
    output lr_pkg::t_coord                   o_pixel_y,
    output logic                             o_pixel_inside,
    output logic                             o_last_pixel
);

    lr_pkg::t_clip     r_clip_width;
    lr_pkg::t_clip     r_clip_height;
    logic              r_in_valid;
    logic              r_kind;
    lr_pkg::t_coord    r_x_start;
    lr_pkg::t_coord    r_y_start;
    lr_pkg::t_coord    r_x_end;
    lr_pkg::t_coord    r_y_end;

    logic              out_free;
    logic              in_accept;
    logic              consume;
    lr_pkg::t_walk_ctl walk_ctl;
    lr_pkg::t_line     setup_line;

    // result slot is free when empty or being taken this cycle
    assign out_free   = !o_out_valid || !i_out_stall;
    assign consume    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_width  <= lr_pkg::CLIP_RESET;
            r_clip_height <= lr_pkg::CLIP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lr_pkg::REG_CLIP_WIDTH:  r_clip_width  <= i_cfg_data;
                lr_pkg::REG_CLIP_HEIGHT: r_clip_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind    <= i_kind;
            r_x_start <= i_x_start;
            r_y_start <= i_y_start;
            r_x_end   <= i_x_end;
            r_y_end   <= i_y_end;
        end
    end

    always_comb begin
        walk_ctl.load = consume && (r_kind == lr_pkg::KIND_LOAD);
        walk_ctl.step = consume && (r_kind == lr_pkg::KIND_STEP);
    end

    lr_setup u_setup (
        .i_x_start (r_x_start),
        .i_y_start (r_y_start),
        .i_x_end   (r_x_end),
        .i_y_end   (r_y_end),
        .o_line    (setup_line)
    );

    lr_walker u_walker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (walk_ctl),
        .i_line         (setup_line),
        .i_clip_width   (r_clip_width),
        .i_clip_height  (r_clip_height),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_inside (o_pixel_inside),
        .o_last_pixel   (o_last_pixel)
    );

endmodule

// ----- tb/line_rasterizer_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rasterizer_checker
// Watches the config port and both channels of the line rasterizer. It keeps
// its own line walker, predicts each pixel and compares the pixel transactions
// field by field, in order.
// ----------------------------------------------------------------------------
module line_rasterizer_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lr_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [lr_pkg::CLIP_BITS-1:0]     i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic                             i_kind,
    input  lr_pkg::t_coord                   i_x_start,
    input  lr_pkg::t_coord                   i_y_start,
    input  lr_pkg::t_coord                   i_x_end,
    input  lr_pkg::t_coord                   i_y_end,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  lr_pkg::t_coord                   i_pixel_x,
    input  lr_pkg::t_coord                   i_pixel_y,
    input  logic                             i_pixel_inside,
    input  logic                             i_last_pixel,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_pixel_count
);

    typedef struct packed {
        lr_pkg::t_coord x;
        lr_pkg::t_coord y;
        logic           in_clip;
        logic           last;
    } t_pixel;

    t_pixel pixel_queue[$];

    lr_pkg::t_clip  clip_w;
    lr_pkg::t_clip  clip_h;
    lr_pkg::t_coord walk_major;
    lr_pkg::t_coord walk_minor;
    lr_pkg::t_coord walk_end;
    lr_pkg::t_delta delta_major;
    lr_pkg::t_delta delta_minor;
    lr_pkg::t_err   walk_err;
    logic           minor_neg;
    logic           steep;
    logic           active;

    task automatic setup_line(input lr_pkg::t_coord xs, input lr_pkg::t_coord ys,
                              input lr_pkg::t_coord xe, input lr_pkg::t_coord ye);
        int             dx;
        int             dy;
        lr_pkg::t_coord a0;
        lr_pkg::t_coord b0;
        lr_pkg::t_coord a1;
        lr_pkg::t_coord b1;
        lr_pkg::t_coord tmp;
        dx = (xs > xe) ? int'(xs) - int'(xe) : int'(xe) - int'(xs);
        dy = (ys > ye) ? int'(ys) - int'(ye) : int'(ye) - int'(ys);
        steep = dy > dx;
        if (steep) begin
            a0 = ys; b0 = xs; a1 = ye; b1 = xe;
        end else begin
            a0 = xs; b0 = ys; a1 = xe; b1 = ye;
        end
        // walk always runs upward on the major axis
        if (a0 > a1) begin
            tmp = a0; a0 = a1; a1 = tmp;
            tmp = b0; b0 = b1; b1 = tmp;
        end
        walk_major  = a0;
        walk_minor  = b0;
        walk_end    = a1;
        delta_major = lr_pkg::t_delta'(a1 - a0);
        delta_minor = (b0 > b1) ? lr_pkg::t_delta'(b0 - b1) : lr_pkg::t_delta'(b1 - b0);
        minor_neg   = b1 < b0;
        walk_err    = lr_pkg::t_err'(int'(delta_minor) - int'(delta_major));
        active      = 1'b1;
    endtask

    task automatic next_pixel();
        t_pixel pix;
        int     err;
        if (!active) return;
        pix.x       = steep ? walk_minor : walk_major;
        pix.y       = steep ? walk_major : walk_minor;
        pix.in_clip = (lr_pkg::t_cmp'(pix.x) < lr_pkg::t_cmp'(clip_w)) &&
                      (lr_pkg::t_cmp'(pix.y) < lr_pkg::t_cmp'(clip_h));
        pix.last    = walk_major == walk_end;
        pixel_queue = {pixel_queue, pix};
        if (pix.last) begin
            active = 1'b0;
        end else begin
            err = int'(walk_err);
            if (err >= 0) begin
                walk_minor = minor_neg ? walk_minor - 1'b1 : walk_minor + 1'b1;
                err -= int'(delta_major);
            end
            err += int'(delta_minor);
            walk_err   = lr_pkg::t_err'(err);
            walk_major = walk_major + 1'b1;
        end
    endtask

    task automatic check_pixel();
        t_pixel want;
        if (pixel_queue.size() == 0) begin
            $error("unexpected pixel transaction: x %0d y %0d", i_pixel_x, i_pixel_y);
            o_fail_count++;
            return;
        end
        want = pixel_queue.pop_front();
        o_pixel_count++;
        if (i_pixel_x !== want.x) begin
            $error("pixel_x mismatch: expected %0d, actual %0d", want.x, i_pixel_x);
            o_fail_count++;
        end
        if (i_pixel_y !== want.y) begin
            $error("pixel_y mismatch: expected %0d, actual %0d", want.y, i_pixel_y);
            o_fail_count++;
        end
        if (i_pixel_inside !== want.in_clip) begin
            $error("pixel_inside mismatch: expected %0d, actual %0d",
                   want.in_clip, i_pixel_inside);
            o_fail_count++;
        end
        if (i_last_pixel !== want.last) begin
            $error("last_pixel mismatch: expected %0d, actual %0d",
                   want.last, i_last_pixel);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clip_w        = lr_pkg::CLIP_RESET;
            clip_h        = lr_pkg::CLIP_RESET;
            walk_major    = '0;
            walk_minor    = '0;
            walk_end      = '0;
            delta_major   = '0;
            delta_minor   = '0;
            walk_err      = '0;
            minor_neg     = 1'b0;
            steep         = 1'b0;
            active        = 1'b0;
            o_fail_count  = 0;
            o_pixel_count = 0;
            pixel_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_pixel();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lr_pkg::REG_CLIP_WIDTH: clip_w = i_cfg_data;
                    lr_pkg::REG_CLIP_HEIGHT: clip_h = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_kind == lr_pkg::KIND_LOAD) begin
                    setup_line(i_x_start, i_y_start, i_x_end, i_y_end);
                end else begin
                    next_pixel();
                end
            end
        end
        o_pending = pixel_queue.size();
    end

endmodule

// ----- tb/line_rasterizer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rasterizer_tb
// Drives the line rasterizer with directed lines and then random line
// sequences under several clip settings, with random idling on both sides.
// The checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module line_rasterizer_tb;

    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 85;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            cfg_we      = 1'b0;
    logic [lr_pkg::CFG_IDX_BITS-1:0] cfg_index   = lr_pkg::REG_CLIP_WIDTH;
    lr_pkg::t_clip                   cfg_data    = '0;
    logic                            in_valid    = 1'b0;
    logic                            kind        = lr_pkg::KIND_LOAD;
    lr_pkg::t_coord                  x_start     = '0;
    lr_pkg::t_coord                  y_start     = '0;
    lr_pkg::t_coord                  x_end       = '0;
    lr_pkg::t_coord                  y_end       = '0;
    logic                            out_stall   = 1'b0;
    logic                            in_stall;
    logic                            out_valid;
    lr_pkg::t_coord                  pixel_x;
    lr_pkg::t_coord                  pixel_y;
    logic                            pixel_inside;
    logic                            last_pixel;

    int fail_count;
    int pending;
    int pixel_count;
    int items_sent  = 0;
    int lines_sent  = 0;
    int stall_left  = 0;
    bit idle_on     = 1'b1;

    lr_pkg::t_clip clip_widths[NUM_PHASES];
    lr_pkg::t_clip clip_heights[NUM_PHASES];

    line_rasterizer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (kind),
        .i_x_start      (x_start),
        .i_y_start      (y_start),
        .i_x_end        (x_end),
        .i_y_end        (y_end),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_pixel_x      (pixel_x),
        .o_pixel_y      (pixel_y),
        .o_pixel_inside (pixel_inside),
        .o_last_pixel   (last_pixel)
    );

    line_rasterizer_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_kind         (kind),
        .i_x_start      (x_start),
        .i_y_start      (y_start),
        .i_x_end        (x_end),
        .i_y_end        (y_end),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_pixel_x      (pixel_x),
        .i_pixel_y      (pixel_y),
        .i_pixel_inside (pixel_inside),
        .i_last_pixel   (last_pixel),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_pixel_count  (pixel_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stalls in random bursts while idling is on
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 10);
            out_stall  <= 1'b1;
        end else begin
            out_stall  <= 1'b0;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic k, input lr_pkg::t_coord xs,
                             input lr_pkg::t_coord ys, input lr_pkg::t_coord xe,
                             input lr_pkg::t_coord ye);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap      = $urandom_range(1, 11);
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        kind     = k;
        x_start  = xs;
        y_start  = ys;
        x_end    = xe;
        y_end    = ye;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
        if (k == lr_pkg::KIND_LOAD) lines_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_load(input int xs, input int ys, input int xe, input int ye);
        send_item(lr_pkg::KIND_LOAD, lr_pkg::t_coord'(xs), lr_pkg::t_coord'(ys),
                  lr_pkg::t_coord'(xe), lr_pkg::t_coord'(ye));
    endtask

    task automatic send_steps(input int count);
        repeat (count) begin
            send_item(lr_pkg::KIND_STEP, lr_pkg::t_coord'($urandom),
                      lr_pkg::t_coord'($urandom), lr_pkg::t_coord'($urandom),
                      lr_pkg::t_coord'($urandom));
        end
    endtask

    task automatic drain_pixels();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_clips(input lr_pkg::t_clip w, input lr_pkg::t_clip h);
        drain_pixels();
        // a trailing load or idle step may still be in the pipe
        repeat (4) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = lr_pkg::REG_CLIP_WIDTH;
        cfg_data  = w;
        @(negedge i_clk);
        cfg_index = lr_pkg::REG_CLIP_HEIGHT;
        cfg_data  = h;
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    task automatic send_random_line();
        int xs;
        int ys;
        int xe;
        int ye;
        int dx;
        int dy;
        int span;
        int count;
        int mode;
        span = ($urandom_range(0, 29) == 0) ? 200 : 12;
        xs   = $urandom_range(0, 1023);
        ys   = $urandom_range(0, 1023);
        dx   = $urandom_range(0, span);
        dy   = $urandom_range(0, span);
        xe   = $urandom_range(0, 1) ? xs + dx : xs - dx;
        ye   = $urandom_range(0, 1) ? ys + dy : ys - dy;
        if (xe < 0 || xe > 1023) xe = 2 * xs - xe;
        if (ye < 0 || ye > 1023) ye = 2 * ys - ye;
        count = ((dx > dy) ? dx : dy) + 1;
        mode  = $urandom_range(0, 9);
        // cut short so the next load replaces it, or run past the end
        if (mode == 0) count = $urandom_range(0, count - 1);
        else if (mode == 1) count += $urandom_range(1, 2);
        send_load(xs, ys, xe, ye);
        send_steps(count);
    endtask

    initial begin
        #2_000_000;
        $display("[line_rasterizer] ERROR");
        $finish;
    end

    initial begin
        int phase_goal;
        clip_widths  = '{11'd0, 11'd1024, 11'd2047, 11'd1, 11'd0, 11'd0};
        clip_heights = '{11'd1024, 11'd0, 11'd2047, 11'd1, 11'd0, 11'd0};
        for (int p = 4; p < NUM_PHASES; p++) begin
            clip_widths[p]  = lr_pkg::t_clip'($urandom_range(1, 1024));
            clip_heights[p] = lr_pkg::t_clip'($urandom_range(1, 1024));
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed lines at the reset clip of 500 by 500
        send_steps(1);
        send_load(1023, 1023, 0, 0);
        send_steps(3);
        send_load(5, 7, 5, 7);
        send_steps(2);
        send_load(10, 20, 12, 26);
        send_steps(7);
        send_load(0, 1023, 4, 1020);
        send_steps(5);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_clips(clip_widths[p], clip_heights[p]);
            if (p == NUM_PHASES - 1) idle_on = 1'b0;
            phase_goal = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_item(logic'($urandom_range(0, 1)), lr_pkg::t_coord'($urandom),
                              lr_pkg::t_coord'($urandom), lr_pkg::t_coord'($urandom),
                              lr_pkg::t_coord'($urandom));
                end else begin
                    send_random_line();
                end
                if (idle_on && $urandom_range(0, 24) == 0) drain_pixels();
            end
        end

        drain_pixels();
        repeat (8) @(negedge i_clk);
        $display("covered %0d lines in %0d input transactions, %0d pixels checked",
                 lines_sent, items_sent, pixel_count);
        $display("under %0d clip settings including zero, 1024 and 2047", NUM_PHASES + 1);
        if (fail_count == 0 && pending == 0) begin
            $display("[line_rasterizer] OK");
        end else begin
            $display("[line_rasterizer] ERROR");
        end
        $finish;
    end

endmodule
